// ===== hw/rtl/dual_stepper_pulse_generator_macros.svh =====
// Assertion macros for the dual stepper pulse generator.
// Uses clk and rst_n of the including module; no other dependencies.
`ifndef DUAL_STEPPER_PULSE_GENERATOR_MACROS_SVH
`define DUAL_STEPPER_PULSE_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define DSPG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define DSPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dspg_pkg.sv =====
// Shared types and constants for the dual stepper pulse generator.
// No dependencies.
package dspg_pkg;

  localparam int unsigned IvW   = 17;
  localparam int unsigned StepW = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 17;

  // Command bytes (ASCII)
  localparam logic [7:0] CMD_STOP_ALL     = 8'h73; // s
  localparam logic [7:0] CMD_RUN_ALL      = 8'h77; // w
  localparam logic [7:0] CMD_GUIDE_LEFT   = 8'h61; // a
  localparam logic [7:0] CMD_GUIDE_RIGHT  = 8'h64; // d
  localparam logic [7:0] CMD_GUIDE_ON     = 8'h71; // q
  localparam logic [7:0] CMD_GUIDE_OFF    = 8'h65; // e
  localparam logic [7:0] CMD_GUIDE_FASTER = 8'h70; // p
  localparam logic [7:0] CMD_GUIDE_SLOWER = 8'h6F; // o
  localparam logic [7:0] CMD_WINDER_FASTER = 8'h6C; // l
  localparam logic [7:0] CMD_WINDER_SLOWER = 8'h6B; // k

  // Configuration register indexes
  localparam logic [CfgAddrW-1:0] REG_GUIDE_MIN  = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_GUIDE_MAX  = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_WINDER_MIN = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_WINDER_MAX = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_STEP       = 3'd4;

  // Reset values
  localparam logic [IvW-1:0]   RST_GUIDE_MIN   = 17'd8000;
  localparam logic [IvW-1:0]   RST_GUIDE_MAX   = 17'd80000;
  localparam logic [IvW-1:0]   RST_WINDER_MIN  = 17'd1000;
  localparam logic [IvW-1:0]   RST_WINDER_MAX  = 17'd10000;
  localparam logic [StepW-1:0] RST_STEP        = 16'd100;
  localparam logic [IvW-1:0]   RST_GUIDE_IV    = 17'd25000;
  localparam logic [IvW-1:0]   RST_WINDER_IV   = 17'd8000;

  // Interval adjust request toward one motor
  typedef struct packed {
    logic shorten;
    logic lengthen;
  } adj_req_t;

endpackage

// ===== hw/rtl/dual_stepper_pulse_generator.sv =====
// Top level of the dual stepper pulse generator: command decode, two step timers.
// Depends on dspg_pkg, dspg_interval_adj and dual_stepper_pulse_generator_macros.svh.
//
// Each request carries a microsecond timestamp and an optional command byte; one
// result comes back per request. Throughput is one request per clock while
// out_tready is high: a request is taken into the input register, and in the
// cycle it moves on, the command is decoded, the interval adjusted and both
// timers compared against the timestamp, all written into the result register,
// which drives out_tvalid. The input register refills in the same cycle the
// result register is taken, so a stalled output holds at most two requests
// inside, one in each register. Configuration writes are taken every cycle
// (cfg_ready is always high); indexes above 4 are ignored, and only bits [15:0]
// of cfg_data are used for the step size.
`include "dual_stepper_pulse_generator_macros.svh"

module dual_stepper_pulse_generator (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: now_us [31:0], rx_byte [39:32]
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [39:0]                     in_tdata,
  // in_tuser: byte_valid [0]
  input  logic                            in_tuser,
  // out_tdata: guide_enable_pin [0], guide_step_pin [1], guide_dir_pin [2],
  // winder_enable_pin [3], winder_step_pin [4], guide_updated [5],
  // winder_updated [6], zero [7]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dspg_pkg::CfgAddrW-1:0]   cfg_addr,
  input  logic [dspg_pkg::CfgDataW-1:0]   cfg_data
);
  import dspg_pkg::*;

  // configuration
  logic [IvW-1:0]   guide_min_r, guide_max_r, winder_min_r, winder_max_r;
  logic [StepW-1:0] step_r;

  // input stage
  logic             s1_valid_r;
  logic [TimeW-1:0] s1_now_r;
  logic [7:0]       s1_byte_r;
  logic             s1_byte_valid_r;
  logic             s1_adv;

  // motor state
  logic [IvW-1:0]   guide_iv_r, winder_iv_r;
  logic [IvW-1:0]   guide_iv_nxt, winder_iv_nxt;
  logic [TimeW-1:0] guide_last_r, winder_last_r;
  logic             guide_en_req_r, guide_en_req_nxt;
  logic             winder_en_req_r, winder_en_req_nxt;
  logic             guide_dir_req_r, guide_dir_req_nxt;
  logic             guide_level_r, winder_level_r;
  logic             guide_en_lat_r, guide_dir_lat_r, winder_en_lat_r;
  adj_req_t         guide_adj, winder_adj;
  logic             guide_hit, winder_hit;

  // result stage
  logic             out_valid_r;
  logic [7:0]       out_data_r;
  logic [7:0]       out_data_nxt;

  assign cfg_ready  = 1'b1;
  assign s1_adv     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      guide_min_r  <= RST_GUIDE_MIN;
      guide_max_r  <= RST_GUIDE_MAX;
      winder_min_r <= RST_WINDER_MIN;
      winder_max_r <= RST_WINDER_MAX;
      step_r       <= RST_STEP;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        REG_GUIDE_MIN:  guide_min_r  <= cfg_data;
        REG_GUIDE_MAX:  guide_max_r  <= cfg_data;
        REG_WINDER_MIN: winder_min_r <= cfg_data;
        REG_WINDER_MAX: winder_max_r <= cfg_data;
        REG_STEP:       step_r       <= cfg_data[StepW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_now_r        <= in_tdata[31:0];
      s1_byte_r       <= in_tdata[39:32];
      s1_byte_valid_r <= in_tuser;
    end
  end

  // command decode
  always_comb begin
    guide_en_req_nxt  = guide_en_req_r;
    winder_en_req_nxt = winder_en_req_r;
    guide_dir_req_nxt = guide_dir_req_r;
    guide_adj         = '0;
    winder_adj        = '0;
    if (s1_byte_valid_r) begin
      unique case (s1_byte_r)
        CMD_STOP_ALL: begin
          guide_en_req_nxt  = 1'b1;
          winder_en_req_nxt = 1'b1;
        end
        CMD_RUN_ALL: begin
          guide_en_req_nxt  = 1'b0;
          winder_en_req_nxt = 1'b0;
        end
        CMD_GUIDE_LEFT:    guide_dir_req_nxt  = 1'b1;
        CMD_GUIDE_RIGHT:   guide_dir_req_nxt  = 1'b0;
        CMD_GUIDE_ON:      guide_en_req_nxt   = 1'b0;
        CMD_GUIDE_OFF:     guide_en_req_nxt   = 1'b1;
        CMD_GUIDE_FASTER:  guide_adj.shorten  = 1'b1;
        CMD_GUIDE_SLOWER:  guide_adj.lengthen = 1'b1;
        CMD_WINDER_FASTER: winder_adj.shorten  = 1'b1;
        CMD_WINDER_SLOWER: winder_adj.lengthen = 1'b1;
        default: ;
      endcase
    end
  end

  dspg_interval_adj u_guide_adj (
    .iv     (guide_iv_r),
    .lo     (guide_min_r),
    .hi     (guide_max_r),
    .step   (step_r),
    .req    (guide_adj),
    .iv_nxt (guide_iv_nxt)
  );

  dspg_interval_adj u_winder_adj (
    .iv     (winder_iv_r),
    .lo     (winder_min_r),
    .hi     (winder_max_r),
    .step   (step_r),
    .req    (winder_adj),
    .iv_nxt (winder_iv_nxt)
  );

  // elapsed time wraps modulo 2^32
  assign guide_hit  = (s1_now_r - guide_last_r) >= {{(TimeW-IvW){1'b0}}, guide_iv_nxt};
  assign winder_hit = (s1_now_r - winder_last_r) >= {{(TimeW-IvW){1'b0}}, winder_iv_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      guide_iv_r      <= RST_GUIDE_IV;
      winder_iv_r     <= RST_WINDER_IV;
      guide_last_r    <= '0;
      winder_last_r   <= '0;
      guide_en_req_r  <= 1'b1;
      winder_en_req_r <= 1'b1;
      guide_dir_req_r <= 1'b0;
      guide_level_r   <= 1'b0;
      winder_level_r  <= 1'b0;
      guide_en_lat_r  <= 1'b0;
      guide_dir_lat_r <= 1'b0;
      winder_en_lat_r <= 1'b0;
    end else if (s1_adv) begin
      guide_iv_r      <= guide_iv_nxt;
      winder_iv_r     <= winder_iv_nxt;
      guide_en_req_r  <= guide_en_req_nxt;
      winder_en_req_r <= winder_en_req_nxt;
      guide_dir_req_r <= guide_dir_req_nxt;
      if (guide_hit) begin
        guide_last_r    <= s1_now_r;
        guide_level_r   <= !guide_level_r;
        guide_en_lat_r  <= guide_en_req_nxt;
        guide_dir_lat_r <= guide_dir_req_nxt;
      end
      if (winder_hit) begin
        winder_last_r   <= s1_now_r;
        winder_level_r  <= !winder_level_r;
        winder_en_lat_r <= winder_en_req_nxt;
      end
    end
  end

  always_comb begin
    out_data_nxt[0] = guide_hit ? guide_en_req_nxt : guide_en_lat_r;
    out_data_nxt[1] = guide_hit ? !guide_level_r : guide_level_r;
    out_data_nxt[2] = guide_hit ? guide_dir_req_nxt : guide_dir_lat_r;
    out_data_nxt[3] = winder_hit ? winder_en_req_nxt : winder_en_lat_r;
    out_data_nxt[4] = winder_hit ? !winder_level_r : winder_level_r;
    out_data_nxt[5] = guide_hit;
    out_data_nxt[6] = winder_hit;
    out_data_nxt[7] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  `DSPG_ASSERT_NEXT(a_adv_gives_result, s1_adv, out_valid_r, "advanced request produced no result")
  `DSPG_ASSERT_NOW(a_stall_only_when_full, !in_tready, s1_valid_r && out_valid_r && !out_tready, "input stalled without a blocked result")
  `DSPG_ASSERT_NEXT(a_guide_restart, s1_adv && guide_hit, guide_last_r == $past(s1_now_r), "guide timer did not restart at the timestamp")
  `DSPG_ASSERT_NEXT(a_guide_toggle, s1_adv && guide_hit, guide_level_r != $past(guide_level_r), "guide step level did not toggle")

endmodule

// ===== hw/rtl/dspg_interval_adj.sv =====
// Interval adjuster (uses dspg_pkg): shortens one motor's half-period by the step
// size if above lo, or lengthens it if below hi; saturates at zero and full width.
module dspg_interval_adj (
  input  logic [dspg_pkg::IvW-1:0]   iv,
  input  logic [dspg_pkg::IvW-1:0]   lo,
  input  logic [dspg_pkg::IvW-1:0]   hi,
  input  logic [dspg_pkg::StepW-1:0] step,
  input  dspg_pkg::adj_req_t         req,
  output logic [dspg_pkg::IvW-1:0]   iv_nxt
);
  import dspg_pkg::*;

  logic [IvW-1:0] step_w;
  logic [IvW:0]   sum;
  logic [IvW-1:0] shortened;
  logic [IvW-1:0] lengthened;

  assign step_w = {{(IvW-StepW){1'b0}}, step};
  assign sum    = {1'b0, iv} + {1'b0, step_w};

  always_comb begin
    shortened = iv;
    if (iv > lo) begin
      shortened = (iv >= step_w) ? (iv - step_w) : '0;
    end
    lengthened = iv;
    if (iv < hi) begin
      // saturate at the top of the register
      lengthened = sum[IvW] ? '1 : sum[IvW-1:0];
    end
    if (req.shorten) begin
      iv_nxt = shortened;
    end else if (req.lengthen) begin
      iv_nxt = lengthened;
    end else begin
      iv_nxt = iv;
    end
  end

endmodule

// ===== tb/dual_stepper_pulse_generator_tb.sv =====
// Testbench for dual_stepper_pulse_generator: directed table plus random phases,
// each result checked against an in-bench model of the two step timers.
// Depends on dspg_pkg and the dual_stepper_pulse_generator RTL.
`timescale 1ns / 100ps

module dual_stepper_pulse_generator_tb;
  import dspg_pkg::*;

  localparam int LIMIT = 200000;
  localparam logic [IvW-1:0] IV_TOP = 17'h1FFFF;

  // One result as it appears in out_tdata[6:0], lowest bit last
  typedef struct packed {
    logic w_upd;
    logic g_upd;
    logic w_step;
    logic w_en;
    logic g_dir;
    logic g_step;
    logic g_en;
  } pins_t;

  typedef struct packed {
    logic                is_cfg;
    logic [CfgAddrW-1:0] idx;
    logic [CfgDataW-1:0] val;
    logic [31:0]         now;
    logic                bv;
    logic [7:0]          code;
    logic                typed;
    pins_t               pins;
  } vec_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [39:0]         in_tdata = '0;
  logic                in_tuser = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [7:0]          out_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgAddrW-1:0] cfg_addr = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // Model copy of the limits and the motor state
  logic [IvW-1:0]   lim_gmin, lim_gmax, lim_wmin, lim_wmax;
  logic [StepW-1:0] iv_step;
  logic [IvW-1:0]   g_iv, w_iv;
  logic [31:0]      g_t0, w_t0;
  logic             g_en_req, w_en_req, g_dir_req;
  logic             g_lvl, w_lvl, g_en_q, g_dir_q, w_en_q;

  pins_t pin_q[$];
  vec_t  plan_q[$];
  int    err_cnt = 0;
  int    items_in = 0;
  int    hold_left = 0;
  int    calm_left = 0;
  bit    hold_done = 1'b0;

  always #2 clk = ~clk;

  dual_stepper_pulse_generator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  task automatic reset_model();
    lim_gmin  = RST_GUIDE_MIN;
    lim_gmax  = RST_GUIDE_MAX;
    lim_wmin  = RST_WINDER_MIN;
    lim_wmax  = RST_WINDER_MAX;
    iv_step   = RST_STEP;
    g_iv      = RST_GUIDE_IV;
    w_iv      = RST_WINDER_IV;
    g_t0      = '0;
    w_t0      = '0;
    g_en_req  = 1'b1;
    w_en_req  = 1'b1;
    g_dir_req = 1'b0;
    g_lvl     = 1'b0;
    w_lvl     = 1'b0;
    g_en_q    = 1'b0;
    g_dir_q   = 1'b0;
    w_en_q    = 1'b0;
  endtask

  task automatic set_limit(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] val);
    case (idx)
      REG_GUIDE_MIN:  lim_gmin = val;
      REG_GUIDE_MAX:  lim_gmax = val;
      REG_WINDER_MIN: lim_wmin = val;
      REG_WINDER_MAX: lim_wmax = val;
      REG_STEP:       iv_step = val[StepW-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [IvW-1:0] iv_shorten(input logic [IvW-1:0] iv,
                                                input logic [IvW-1:0] lo);
    if (iv <= lo) return iv;
    return (iv >= {1'b0, iv_step}) ? iv - {1'b0, iv_step} : '0;
  endfunction

  function automatic logic [IvW-1:0] iv_lengthen(input logic [IvW-1:0] iv,
                                                 input logic [IvW-1:0] hi);
    logic [IvW:0] sum;
    sum = {1'b0, iv} + {2'b00, iv_step};
    if (iv >= hi) return iv;
    return (sum > {1'b0, IV_TOP}) ? IV_TOP : sum[IvW-1:0];
  endfunction

  // Decode the byte, then run both timers, guide first
  function automatic pins_t next_pins(input logic [31:0] now, input logic bv,
                                      input logic [7:0] code);
    pins_t       p;
    logic [31:0] gap;
    p = '0;
    if (bv) begin
      case (code)
        CMD_STOP_ALL: begin
          g_en_req = 1'b1;
          w_en_req = 1'b1;
        end
        CMD_RUN_ALL: begin
          g_en_req = 1'b0;
          w_en_req = 1'b0;
        end
        CMD_GUIDE_LEFT:    g_dir_req = 1'b1;
        CMD_GUIDE_RIGHT:   g_dir_req = 1'b0;
        CMD_GUIDE_ON:      g_en_req = 1'b0;
        CMD_GUIDE_OFF:     g_en_req = 1'b1;
        CMD_GUIDE_FASTER:  g_iv = iv_shorten(g_iv, lim_gmin);
        CMD_GUIDE_SLOWER:  g_iv = iv_lengthen(g_iv, lim_gmax);
        CMD_WINDER_FASTER: w_iv = iv_shorten(w_iv, lim_wmin);
        CMD_WINDER_SLOWER: w_iv = iv_lengthen(w_iv, lim_wmax);
        default: ;
      endcase
    end
    gap = now - g_t0;
    if (gap >= {15'd0, g_iv}) begin
      g_t0    = now;
      g_lvl   = ~g_lvl;
      g_en_q  = g_en_req;
      g_dir_q = g_dir_req;
      p.g_upd = 1'b1;
    end
    gap = now - w_t0;
    if (gap >= {15'd0, w_iv}) begin
      w_t0    = now;
      w_lvl   = ~w_lvl;
      w_en_q  = w_en_req;
      p.w_upd = 1'b1;
    end
    p.g_en   = g_en_q;
    p.g_step = g_lvl;
    p.g_dir  = g_dir_q;
    p.w_en   = w_en_q;
    p.w_step = w_lvl;
    return p;
  endfunction

  function automatic vec_t item_row(input logic [31:0] now, input logic bv,
                                    input logic [7:0] code);
    vec_t v;
    v      = '0;
    v.now  = now;
    v.bv   = bv;
    v.code = code;
    return v;
  endfunction

  function automatic vec_t typed_row(input logic [31:0] now, input logic bv,
                                     input logic [7:0] code, input pins_t pins);
    vec_t v;
    v       = item_row(now, bv, code);
    v.typed = 1'b1;
    v.pins  = pins;
    return v;
  endfunction

  function automatic vec_t cfg_row(input logic [CfgAddrW-1:0] idx,
                                   input logic [CfgDataW-1:0] val);
    vec_t v;
    v        = '0;
    v.is_cfg = 1'b1;
    v.idx    = idx;
    v.val    = val;
    return v;
  endfunction

  function automatic logic [CfgDataW-1:0] pick_limit();
    int sel;
    sel = $urandom_range(3);
    if (sel == 0) return '0;
    if (sel == 1) return IV_TOP;
    return CfgDataW'($urandom_range(IV_TOP));
  endfunction

  // Bit 16 rides along at random; the step register keeps only [15:0]
  function automatic logic [CfgDataW-1:0] pick_step();
    int               sel;
    logic [StepW-1:0] s;
    sel = $urandom_range(3);
    if (sel == 0) s = '0;
    else if (sel == 1) s = 16'hFFFF;
    else s = StepW'($urandom_range(8000));
    return {1'($urandom_range(1)), s};
  endfunction

  function automatic logic [7:0] pick_cmd();
    case ($urandom_range(9))
      0: return CMD_STOP_ALL;
      1: return CMD_RUN_ALL;
      2: return CMD_GUIDE_LEFT;
      3: return CMD_GUIDE_RIGHT;
      4: return CMD_GUIDE_ON;
      5: return CMD_GUIDE_OFF;
      6: return CMD_GUIDE_FASTER;
      7: return CMD_GUIDE_SLOWER;
      8: return CMD_WINDER_FASTER;
      default: return CMD_WINDER_SLOWER;
    endcase
  endfunction

  task automatic send_req(input logic [31:0] now, input logic bv, input logic [7:0] code,
                          input logic typed, input pins_t typed_pins);
    bit    idle_ok;
    pins_t p;
    idle_ok = !(items_in >= 200 && items_in < 320);
    cfg_valid <= 1'b0;
    while (idle_ok && $urandom_range(99) < 14) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {code, now};
    in_tuser  <= bv;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    p = next_pins(now, bv, code);
    pin_q.push_back(typed ? typed_pins : p);
    items_in++;
  endtask

  // Hold new requests back until every pending result is out
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pin_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    set_limit(idx, val);
  endtask

  task automatic check_field(input string name, input logic want, input logic got);
    if (want !== got) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      err_cnt++;
    end
  endtask

  // Result sink: random stalls, one long hold-off, then a calm stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
      if (hold_left == 1) calm_left <= 250;
    end else if (!hold_done && items_in >= 100) begin
      hold_done  <= 1'b1;
      hold_left  <= 300;
      out_tready <= 1'b0;
    end else if (calm_left != 0) begin
      out_tready <= 1'b1;
      calm_left  <= calm_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= 14);
    end
  end

  always @(posedge clk) begin : result_check
    pins_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      if (pin_q.size() == 0) begin
        $error("result 0x%02h with no request pending", out_tdata);
        err_cnt++;
      end else begin
        want = pin_q.pop_front();
        got  = pins_t'(out_tdata[6:0]);
        check_field("guide_enable_pin", want.g_en, got.g_en);
        check_field("guide_step_pin", want.g_step, got.g_step);
        check_field("guide_dir_pin", want.g_dir, got.g_dir);
        check_field("winder_enable_pin", want.w_en, got.w_en);
        check_field("winder_step_pin", want.w_step, got.w_step);
        check_field("guide_updated", want.g_upd, got.g_upd);
        check_field("winder_updated", want.w_upd, got.w_upd);
        check_field("pad", 1'b0, out_tdata[7]);
      end
    end
  end

  initial begin : watchdog
    int cyc;
    cyc = 0;
    while (cyc < LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    vec_t        v;
    int          ph, k, sel;
    logic [31:0] t, now;
    logic        bv;
    logic [7:0]  code;

    // Reset values, plain requests, wrap of the timestamp
    plan_q.push_back(typed_row(32'd0, 1'b0, 8'h00, pins_t'(7'h00)));
    plan_q.push_back(typed_row(32'd8000, 1'b0, CMD_RUN_ALL, pins_t'(7'h58)));
    plan_q.push_back(typed_row(32'd8001, 1'b1, CMD_RUN_ALL, pins_t'(7'h18)));
    plan_q.push_back(typed_row(32'd25000, 1'b1, CMD_GUIDE_LEFT, pins_t'(7'h66)));
    plan_q.push_back(typed_row(32'hFFFF_FFFF, 1'b1, CMD_GUIDE_RIGHT, pins_t'(7'h70)));
    plan_q.push_back(typed_row(32'd100, 1'b1, CMD_GUIDE_OFF, pins_t'(7'h10)));
    plan_q.push_back(item_row(32'd200, 1'b1, CMD_GUIDE_ON));
    plan_q.push_back(item_row(32'd300, 1'b0, CMD_STOP_ALL));
    plan_q.push_back(item_row(32'd400, 1'b1, 8'hFF));
    plan_q.push_back(item_row(32'd500, 1'b1, 8'h00));
    plan_q.push_back(item_row(32'd600, 1'b1, CMD_GUIDE_FASTER));
    plan_q.push_back(item_row(32'd700, 1'b1, CMD_GUIDE_SLOWER));
    plan_q.push_back(item_row(32'd800, 1'b1, CMD_WINDER_FASTER));
    plan_q.push_back(item_row(32'd900, 1'b1, CMD_WINDER_SLOWER));
    plan_q.push_back(item_row(32'd30000, 1'b1, CMD_STOP_ALL));
    // Widest limits and largest step: intervals saturate at zero and at the top
    plan_q.push_back(cfg_row(REG_STEP, 17'h1FFFF));
    plan_q.push_back(cfg_row(REG_GUIDE_MIN, 17'd0));
    plan_q.push_back(cfg_row(REG_GUIDE_MAX, IV_TOP));
    plan_q.push_back(cfg_row(REG_WINDER_MIN, 17'd0));
    plan_q.push_back(cfg_row(REG_WINDER_MAX, IV_TOP));
    plan_q.push_back(item_row(32'd30001, 1'b1, CMD_GUIDE_FASTER));
    plan_q.push_back(item_row(32'd30002, 1'b1, CMD_WINDER_FASTER));
    plan_q.push_back(item_row(32'd30002, 1'b1, CMD_RUN_ALL));
    plan_q.push_back(item_row(32'd30003, 1'b1, CMD_GUIDE_SLOWER));
    plan_q.push_back(item_row(32'd30004, 1'b1, CMD_GUIDE_SLOWER));
    plan_q.push_back(item_row(32'd30005, 1'b1, CMD_GUIDE_SLOWER));
    plan_q.push_back(item_row(32'd30006, 1'b1, CMD_WINDER_SLOWER));
    plan_q.push_back(item_row(32'd30007, 1'b1, CMD_WINDER_SLOWER));
    plan_q.push_back(item_row(32'd30008, 1'b1, CMD_WINDER_SLOWER));
    plan_q.push_back(cfg_row(REG_STEP, 17'd0));
    plan_q.push_back(item_row(32'd30100, 1'b1, CMD_GUIDE_FASTER));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    reset_model();

    foreach (plan_q[i]) begin
      v = plan_q[i];
      if (v.is_cfg) begin
        drain();
        write_reg(v.idx, v.val);
      end else begin
        send_req(v.now, v.bv, v.code, v.typed, v.pins);
      end
    end

    t = 32'd30100;
    for (ph = 0; ph < 8; ph++) begin
      drain();
      if ($urandom_range(3) != 0) write_reg(REG_GUIDE_MIN, pick_limit());
      if ($urandom_range(3) != 0) write_reg(REG_GUIDE_MAX, pick_limit());
      if ($urandom_range(3) != 0) write_reg(REG_WINDER_MIN, pick_limit());
      if ($urandom_range(3) != 0) write_reg(REG_WINDER_MAX, pick_limit());
      if ($urandom_range(3) != 0) write_reg(REG_STEP, pick_step());
      for (k = 0; k < 62; k++) begin
        // Mostly forward time in short, mid and long hops; now and then a jump
        sel = $urandom_range(99);
        if (sel < 10) t = $urandom();
        else if (sel < 40) t = t + $urandom_range(300);
        else if (sel < 80) t = t + $urandom_range(30000);
        else t = t + $urandom_range(140000);
        now  = t;
        bv   = ($urandom_range(99) < 70);
        code = ($urandom_range(99) < 85) ? pick_cmd() : 8'($urandom_range(255));
        if (!bv) code = 8'($urandom_range(255));
        send_req(now, bv, code, 1'b0, '0);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (err_cnt == 0 && pin_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
